// ===== rtl/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and codes for the readout frame checker: frame phases, status
// codes, configuration set and the input and result payloads.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_CRC1   = 3'd3;
  localparam logic [2:0] PH_FILL   = 3'd4;
  localparam logic [2:0] PH_CRC2   = 3'd5;
  localparam logic [2:0] PH_STOP   = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_FAULT     = 3'd2;
  localparam logic [2:0] ST_BAD_HDR   = 3'd3;
  localparam logic [2:0] ST_BAD_DATA  = 3'd4;
  localparam logic [2:0] ST_CTL_CRC   = 3'd5;
  localparam logic [2:0] ST_CTL_FILL  = 3'd6;
  localparam logic [2:0] ST_BAD_STOP  = 3'd7;

  localparam logic [2:0] REG_SAMPLES_LESS_ONE = 3'd0;
  localparam logic [2:0] REG_BLOCKS_PER_FRAME = 3'd1;
  localparam logic [2:0] REG_SOF_WORD         = 3'd2;
  localparam logic [2:0] REG_EOF_WORD         = 3'd3;
  localparam logic [2:0] REG_PATTERN_BASE     = 3'd4;

  localparam logic [4:0]  RST_SAMPLES_LESS_ONE = 5'd7;
  localparam logic [4:0]  RST_BLOCKS_PER_FRAME = 5'd16;
  localparam logic [31:0] RST_SOF_WORD         = 32'h1111_1110;
  localparam logic [31:0] RST_EOF_WORD         = 32'hffff_fff0;
  localparam logic [31:0] RST_PATTERN_BASE     = 32'h0001_0101;

  typedef struct packed {
    logic [4:0]  samples_less_one;
    logic [4:0]  blocks_per_frame;
    logic [31:0] sof_word;
    logic [31:0] eof_word;
    logic [31:0] pattern_base;
  } cfg_t;

  typedef struct packed {
    logic [31:0] link_word;
    logic        is_control;
    logic        link_fault;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        data_mismatch;
    logic [31:0] mismatch_total;
    logic        frame_done;
    logic [4:0]  block_index;
    logic [4:0]  sample_index;
  } out_item_t;

endpackage

// ===== rtl/rfc_if.sv =====
// ----------------------------------------------------------------------------
// rfc_if
// Valid/ready channels of the readout frame checker: link words in,
// check results out.
// ----------------------------------------------------------------------------
interface rfc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] link_word;
  logic        is_control;
  logic        link_fault;

  modport source (output valid, output link_word, output is_control,
                  output link_fault, input ready);
  modport sink   (input valid, input link_word, input is_control,
                  input link_fault, output ready);
endinterface

interface rfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        data_mismatch;
  logic [31:0] mismatch_total;
  logic        frame_done;
  logic [4:0]  block_index;
  logic [4:0]  sample_index;

  modport source (output valid, output status, output data_mismatch,
                  output mismatch_total, output frame_done,
                  output block_index, output sample_index, input ready);
  modport sink   (input valid, input status, input data_mismatch,
                  input mismatch_total, input frame_done,
                  input block_index, input sample_index, output ready);
endinterface

// ===== rtl/rfc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rfc_cfg_regs
// APB-style register file holding the frame layout, the control words and
// the data pattern base.
// ----------------------------------------------------------------------------
module rfc_cfg_regs
  import rfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_less_one <= RST_SAMPLES_LESS_ONE;
      cfg_r.blocks_per_frame <= RST_BLOCKS_PER_FRAME;
      cfg_r.sof_word         <= RST_SOF_WORD;
      cfg_r.eof_word         <= RST_EOF_WORD;
      cfg_r.pattern_base     <= RST_PATTERN_BASE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SAMPLES_LESS_ONE: cfg_r.samples_less_one <= pwdata[4:0];
        REG_BLOCKS_PER_FRAME: cfg_r.blocks_per_frame <= pwdata[4:0];
        REG_SOF_WORD:         cfg_r.sof_word         <= pwdata;
        REG_EOF_WORD:         cfg_r.eof_word         <= pwdata;
        REG_PATTERN_BASE:     cfg_r.pattern_base     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SAMPLES_LESS_ONE: prdata = {27'd0, cfg_r.samples_less_one};
      REG_BLOCKS_PER_FRAME: prdata = {27'd0, cfg_r.blocks_per_frame};
      REG_SOF_WORD:         prdata = cfg_r.sof_word;
      REG_EOF_WORD:         prdata = cfg_r.eof_word;
      REG_PATTERN_BASE:     prdata = cfg_r.pattern_base;
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/rfc_engine.sv =====
// ----------------------------------------------------------------------------
// rfc_engine
// Frame state machine and mismatch counter. Checks the word held in the input
// register and advances the frame state when the word moves on.
// ----------------------------------------------------------------------------
module rfc_engine
  import rfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_item_t    item,
  input  cfg_t        cfg,
  output out_item_t   result,
  output logic [2:0]  phase,
  output logic [31:0] mism_cnt
);

  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  block_r, block_nxt;
  logic [4:0]  sample_r, sample_nxt;
  logic [31:0] mism_r, mism_nxt;
  logic [31:0] expect_word;
  logic [5:0]  block_inc;
  logic [2:0]  status;
  logic        mism;
  logic        done;
  logic        last_sample;

  assign expect_word = cfg.pattern_base << sample_r;
  assign block_inc   = {1'b0, block_r} + 6'd1;
  assign last_sample = sample_r >= cfg.samples_less_one;

  always_comb begin
    phase_nxt  = phase_r;
    block_nxt  = block_r;
    sample_nxt = sample_r;
    mism_nxt   = mism_r;
    status     = ST_OK;
    mism       = 1'b0;
    done       = 1'b0;

    if (item.link_fault) begin
      status = ST_FAULT;
    end else begin
      case (phase_r)
        PH_START: begin
          if (item.is_control && item.link_word != cfg.sof_word) begin
            status = ST_BAD_START;
          end else begin
            block_nxt  = 5'd0;
            sample_nxt = 5'd0;
            phase_nxt  = (cfg.blocks_per_frame == 5'd0) ? PH_STOP : PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (item.is_control || !item.link_word[31]) begin
            status = ST_BAD_HDR;
          end else begin
            sample_nxt = 5'd0;
            phase_nxt  = PH_DATA;
          end
        end
        PH_DATA: begin
          if (item.is_control || item.link_word[31]) begin
            status = ST_BAD_DATA;
          end else begin
            if (item.link_word != expect_word) begin
              mism = 1'b1;
              if (mism_r != 32'hffff_ffff) begin
                mism_nxt = mism_r + 32'd1;
              end
            end
            if (last_sample) begin
              sample_nxt = 5'd0;
              phase_nxt  = PH_CRC1;
            end else begin
              sample_nxt = sample_r + 5'd1;
            end
          end
        end
        PH_CRC1: begin
          if (item.is_control) begin
            status = ST_CTL_CRC;
          end else begin
            sample_nxt = 5'd0;
            phase_nxt  = PH_FILL;
          end
        end
        PH_FILL: begin
          if (item.is_control) begin
            status = ST_CTL_FILL;
          end else if (last_sample) begin
            sample_nxt = 5'd0;
            phase_nxt  = PH_CRC2;
          end else begin
            sample_nxt = sample_r + 5'd1;
          end
        end
        PH_CRC2: begin
          if (item.is_control) begin
            status = ST_CTL_CRC;
          end else begin
            sample_nxt = 5'd0;
            if (block_inc >= {1'b0, cfg.blocks_per_frame}) begin
              block_nxt = 5'd0;
              phase_nxt = PH_STOP;
            end else begin
              block_nxt = block_inc[4:0];
              phase_nxt = PH_HEADER;
            end
          end
        end
        default: begin
          if (item.is_control && item.link_word != cfg.eof_word) begin
            status = ST_BAD_STOP;
          end else begin
            done       = 1'b1;
            phase_nxt  = PH_START;
            block_nxt  = 5'd0;
            sample_nxt = 5'd0;
          end
        end
      endcase
    end

    if (status != ST_OK) begin
      done       = 1'b1;
      phase_nxt  = PH_START;
      block_nxt  = 5'd0;
      sample_nxt = 5'd0;
    end
  end

  always_comb begin
    result.status         = status;
    result.data_mismatch  = mism;
    result.mismatch_total = mism_nxt;
    result.frame_done     = done;
    result.block_index    = (phase_r >= PH_HEADER && phase_r <= PH_CRC2) ? block_r : 5'd0;
    result.sample_index   = (phase_r == PH_DATA || phase_r == PH_FILL) ? sample_r : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      block_r  <= 5'd0;
      sample_r <= 5'd0;
      mism_r   <= 32'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      block_r  <= block_nxt;
      sample_r <= sample_nxt;
      mism_r   <= mism_nxt;
    end
  end

  assign phase    = phase_r;
  assign mism_cnt = mism_r;

endmodule

// ===== rtl/readout_frame_checker.sv =====
// ----------------------------------------------------------------------------
// readout_frame_checker
// Checks digitizer readout frames word by word and reports one result per
// received link word.
// ----------------------------------------------------------------------------
// Link words enter on in_ch and each produces exactly one result on out_ch;
// both channels transfer when valid and ready are high at a clock edge.
// A word is captured in an input register, checked by the frame state machine
// while it is held there and its result loaded into the output register, from
// which it transfers on out_ch when out_ch.ready is high.
// Throughput is one word per clock while out_ch does not stall; the frame state
// update of one word is ready for the next word in the following cycle.
// When out_ch stalls, the output register holds its result and the input
// register can still take one more word; in_ch.ready drops only when both
// are full and out_ch.ready is low.
// Synchronous reset clears both registers' valid flags, returns the checker
// to waiting for a start word, clears the mismatch total and restores the
// register defaults. Registers are written through the APB port; the user must
// write them only while no word is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module readout_frame_checker
  import rfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rfc_in_if.sink      in_ch,
  rfc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  in_item_t    s1_item_r;
  logic        s1_valid_r;
  out_item_t   out_item_r;
  logic        out_valid_r;
  out_item_t   result;
  logic        out_load;
  logic        in_xfer;
  logic [2:0]  phase;
  logic [31:0] mism_cnt;

  rfc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfc_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (out_load),
    .item     (s1_item_r),
    .cfg      (cfg),
    .result   (result),
    .phase    (phase),
    .mism_cnt (mism_cnt)
  );

  assign out_load    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || out_load;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.link_word  <= in_ch.link_word;
      s1_item_r.is_control <= in_ch.is_control;
      s1_item_r.link_fault <= in_ch.link_fault;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_item_r.status;
  assign out_ch.data_mismatch  = out_item_r.data_mismatch;
  assign out_ch.mismatch_total = out_item_r.mismatch_total;
  assign out_ch.frame_done     = out_item_r.frame_done;
  assign out_ch.block_index    = out_item_r.block_index;
  assign out_ch.sample_index   = out_item_r.sample_index;

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while both registers are full and stalled");

  a_done_returns_to_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && result.frame_done) |=> (phase == PH_START))
    else $error("frame ended but checker is not waiting for a start word");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (mism_cnt >= $past(mism_cnt)))
    else $error("mismatch total decreased");

  a_mismatch_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.data_mismatch) |-> (out_item_r.status == ST_OK))
    else $error("data mismatch flagged on a faulted word");
`endif

endmodule
